@@ hw/rtl/sste_pkg.sv @@
package sste_pkg;

    localparam int DEFAULT_ENTRIES = 16;

    localparam int ADDR_W  = 48;
    localparam int LEVEL_W = 16;
    localparam int STAMP_W = 32;
    localparam int AGE_W   = 31;
    localparam int FUNC_W  = 3;
    localparam int COUNT_W = 5;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(1000);

    localparam logic [FUNC_W-1:0] OP_OBSERVE = 3'd0;
    localparam logic [FUNC_W-1:0] OP_LOOKUP  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_FORGET  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_SIZE    = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]         addr;
        logic signed [LEVEL_W-1:0] level;
        logic [STAMP_W-1:0]        stamp;
    } slot_t;

endpackage

@@ hw/rtl/sste_ram.sv @@
module sste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/signal_strength_table_with_expiry.sv @@
// Table of signal levels keyed by 48-bit device address, ENTRIES slots deep, one item at a
// time. Slot contents sit in a single-port-read slot memory that is scanned one slot per
// cycle; valid bits and the entry count are flip-flops. Observe, lookup and forget scan the
// slots (a match ends the scan early, an observe of a new address always scans every slot);
// clear, size and unused codes skip the scan. The next item is accepted once the previous
// result is registered, even if it is not yet taken. Lookup counts an entry as fresh when
// (stamp_ms - stored stamp), as a signed 32-bit value, is negative or at most max_age_ms.
// Observe of a new address into a full table changes nothing and sets dropped. The user
// writes the max_age_ms port only while the table is idle; the block does not enforce it.
module signal_strength_table_with_expiry #(
    parameter int ENTRIES = sste_pkg::DEFAULT_ENTRIES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sste_pkg::AGE_W-1:0]             max_age_ms,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [sste_pkg::FUNC_W-1:0]            func,
    input  logic [sste_pkg::ADDR_W-1:0]            device_address,
    input  logic signed [sste_pkg::LEVEL_W-1:0]    signal_level,
    input  logic [sste_pkg::STAMP_W-1:0]           stamp_ms,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   hit,
    output logic signed [sste_pkg::LEVEL_W-1:0]    stored_level,
    output logic                                   dropped,
    output logic [sste_pkg::COUNT_W-1:0]           entry_count
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > sste_pkg::COUNT_W) ? CW : sste_pkg::COUNT_W;
    localparam int SW = $bits(sste_pkg::slot_t);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [sste_pkg::AGE_W-1:0]        age_reg;
    logic [ENTRIES-1:0]                valid_reg, valid_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [IW:0]                       rd_idx_reg, rd_idx_next;
    logic [IW:0]                       cmp_idx_reg, cmp_idx_next;
    logic                              cmp_vld_reg, cmp_vld_next;
    logic                              found_reg, found_next;
    logic [IW-1:0]                     slot_reg, slot_next;
    logic                              free_vld_reg, free_vld_next;
    logic [IW-1:0]                     free_reg, free_next;
    logic                              out_valid_reg, out_valid_next;

    logic [sste_pkg::FUNC_W-1:0]       op_reg;
    logic [sste_pkg::ADDR_W-1:0]       key_reg;
    logic signed [sste_pkg::LEVEL_W-1:0] level_reg;
    logic [sste_pkg::STAMP_W-1:0]      stamp_reg;
    logic signed [sste_pkg::LEVEL_W-1:0] f_level_reg;
    logic [sste_pkg::STAMP_W-1:0]      f_stamp_reg;
    logic                              hit_reg, dropped_reg;
    logic signed [sste_pkg::LEVEL_W-1:0] lvl_out_reg;
    logic [sste_pkg::COUNT_W-1:0]      cnt_out_reg;

    logic                              in_fire;
    logic                              ram_wr_en;
    logic [IW-1:0]                     ram_wr_addr;
    sste_pkg::slot_t                   ram_wr_data;
    logic                              ram_rd_en;
    logic [SW-1:0]                     ram_rd_raw;
    sste_pkg::slot_t                   ram_rd_data;
    logic                              match_now;
    logic                              fin_go;
    logic                              fresh;
    logic [sste_pkg::STAMP_W-1:0]      age_diff;
    logic [XW-1:0]                     cnt_x;
    logic                              hit_next, dropped_next;

    assign ram_rd_data = sste_pkg::slot_t'(ram_rd_raw);

    sste_ram #(
        .WIDTH (SW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[IW-1:0]),
        .rd_data (ram_rd_raw)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hit          = hit_reg;
    assign stored_level = lvl_out_reg;
    assign dropped      = dropped_reg;
    assign entry_count  = cnt_out_reg;

    assign match_now = (state_reg == ST_SCAN) && cmp_vld_reg
                       && valid_reg[cmp_idx_reg[IW-1:0]]
                       && (ram_rd_data.addr == key_reg);
    assign ram_rd_en = (state_reg == ST_SCAN) && (rd_idx_reg < (IW+1)'(ENTRIES)) && !match_now;
    assign fin_go    = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    assign age_diff = stamp_reg - f_stamp_reg;
    assign fresh    = age_diff[sste_pkg::STAMP_W-1]
                      || (age_diff[sste_pkg::AGE_W-1:0] <= age_reg);

    assign ram_wr_data.addr  = key_reg;
    assign ram_wr_data.level = level_reg;
    assign ram_wr_data.stamp = stamp_reg;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = 1'b0;
        found_next     = found_reg;
        slot_next      = slot_reg;
        free_vld_next  = free_vld_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = slot_reg;
        hit_next       = 1'b0;
        dropped_next   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rd_idx_next   = '0;
                    found_next    = 1'b0;
                    free_vld_next = 1'b0;
                    if (func inside {sste_pkg::OP_OBSERVE, sste_pkg::OP_LOOKUP,
                                     sste_pkg::OP_FORGET})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ram_rd_en)
                begin
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    cmp_vld_next = 1'b1;
                end
                if (match_now)
                begin
                    found_next = 1'b1;
                    slot_next  = cmp_idx_reg[IW-1:0];
                    state_next = ST_FIN;
                end
                else if (cmp_vld_reg && !valid_reg[cmp_idx_reg[IW-1:0]] && !free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_next     = cmp_idx_reg[IW-1:0];
                end
                if (!cmp_vld_reg && rd_idx_reg == (IW+1)'(ENTRIES))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    case (op_reg)
                        sste_pkg::OP_OBSERVE:
                        begin
                            if (found_reg)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = slot_reg;
                            end
                            else if (free_vld_reg)
                            begin
                                ram_wr_en             = 1'b1;
                                ram_wr_addr           = free_reg;
                                valid_next[free_reg]  = 1'b1;
                                count_next            = count_reg + 1'b1;
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        sste_pkg::OP_LOOKUP:
                        begin
                            hit_next = found_reg && fresh;
                        end
                        sste_pkg::OP_FORGET:
                        begin
                            if (found_reg)
                            begin
                                valid_next[slot_reg] = 1'b0;
                                count_next           = count_reg - 1'b1;
                            end
                        end
                        sste_pkg::OP_CLEAR:
                        begin
                            valid_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_x = XW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            age_reg       <= sste_pkg::MAX_AGE_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            free_vld_reg  <= 1'b0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                age_reg <= max_age_ms;
            end
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            slot_reg      <= slot_next;
            free_vld_reg  <= free_vld_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the item, the matched slot's fields and the result beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= func;
            key_reg   <= device_address;
            level_reg <= signal_level;
            stamp_reg <= stamp_ms;
        end
        if (match_now)
        begin
            f_level_reg <= ram_rd_data.level;
            f_stamp_reg <= ram_rd_data.stamp;
        end
        if (fin_go)
        begin
            hit_reg     <= hit_next;
            lvl_out_reg <= hit_next ? f_level_reg : '0;
            dropped_reg <= dropped_next;
            cnt_out_reg <= (cnt_x > XW'(31)) ? sste_pkg::COUNT_W'(31)
                                              : cnt_x[sste_pkg::COUNT_W-1:0];
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS       = sste_pkg::DEFAULT_ENTRIES;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 175;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 450;
    localparam int STALL_LIMIT = 2000;
    localparam int COUNT_TOP   = (1 << sste_pkg::COUNT_W) - 1;

    localparam logic [sste_pkg::FUNC_W-1:0]  OP_SPARE_LO = 3'd5;
    localparam logic [sste_pkg::FUNC_W-1:0]  OP_SPARE_HI = 3'd7;
    localparam logic [sste_pkg::ADDR_W-1:0]  ADDR_TOP    = {sste_pkg::ADDR_W{1'b1}};
    localparam logic [sste_pkg::AGE_W-1:0]   AGE_TOP     = {sste_pkg::AGE_W{1'b1}};
    localparam logic [sste_pkg::STAMP_W-1:0] STAMP_TOP   = {sste_pkg::STAMP_W{1'b1}};

    typedef struct packed {
        logic [sste_pkg::FUNC_W-1:0]         func;
        logic [sste_pkg::ADDR_W-1:0]         addr;
        logic signed [sste_pkg::LEVEL_W-1:0] level;
        logic [sste_pkg::STAMP_W-1:0]        stamp;
    } item_t;

    typedef struct packed {
        logic                                hit;
        logic signed [sste_pkg::LEVEL_W-1:0] level;
        logic                                dropped;
        logic [sste_pkg::COUNT_W-1:0]        count;
    } reading_t;

    typedef struct {
        item_t    it;
        int       reps;
        bit       typed;
        reading_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [sste_pkg::AGE_W-1:0]          max_age_ms;

    logic                                in_valid;
    logic                                in_ready;
    logic [sste_pkg::FUNC_W-1:0]         func;
    logic [sste_pkg::ADDR_W-1:0]         device_address;
    logic signed [sste_pkg::LEVEL_W-1:0] signal_level;
    logic [sste_pkg::STAMP_W-1:0]        stamp_ms;

    logic                                out_valid;
    logic                                out_ready;
    logic                                hit;
    logic signed [sste_pkg::LEVEL_W-1:0] stored_level;
    logic                                dropped;
    logic [sste_pkg::COUNT_W-1:0]        entry_count;

    signal_strength_table_with_expiry #(
        .ENTRIES(SLOTS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_age_ms     (max_age_ms),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .device_address (device_address),
        .signal_level   (signal_level),
        .stamp_ms       (stamp_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .stored_level   (stored_level),
        .dropped        (dropped),
        .entry_count    (entry_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // table shadow
    logic                                slot_used [SLOTS];
    logic [sste_pkg::ADDR_W-1:0]         slot_key  [SLOTS];
    logic signed [sste_pkg::LEVEL_W-1:0] slot_lvl  [SLOTS];
    logic [sste_pkg::STAMP_W-1:0]        slot_time [SLOTS];
    int                                  used_count;
    logic [sste_pkg::AGE_W-1:0]          age_limit;

    reading_t                    pending_results [$];
    row_t                        plan [$];
    logic [sste_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [sste_pkg::STAMP_W-1:0] clock_ms;

    int  items_sent;
    int  results_seen;
    int  cfg_writes;
    int  lookup_hits;
    int  full_drops;
    int  errors;
    bit  steady;
    bit  receiver_held;

    function automatic int find_slot(logic [sste_pkg::ADDR_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i])
                return i;
        return -1;
    endfunction

    function automatic reading_t table_step(item_t it);
        reading_t                     r;
        int                           s;
        logic [sste_pkg::STAMP_W-1:0] age;
        r = '0;
        s = find_slot(it.addr);
        case (it.func)
            sste_pkg::OP_OBSERVE:
            begin
                if (s < 0)
                begin
                    s = find_free();
                    if (s >= 0)
                    begin
                        slot_used[s] = 1'b1;
                        slot_key[s]  = it.addr;
                        used_count++;
                    end
                    else
                    begin
                        r.dropped = 1'b1;
                        full_drops++;
                    end
                end
                if (s >= 0)
                begin
                    slot_lvl[s]  = it.level;
                    slot_time[s] = it.stamp;
                end
            end
            sste_pkg::OP_LOOKUP:
            begin
                if (s >= 0)
                begin
                    age = it.stamp - slot_time[s];
                    if (age[sste_pkg::STAMP_W-1] || age <= {1'b0, age_limit})
                    begin
                        r.hit   = 1'b1;
                        r.level = slot_lvl[s];
                        lookup_hits++;
                    end
                end
            end
            sste_pkg::OP_FORGET:
            begin
                if (s >= 0)
                begin
                    slot_used[s] = 1'b0;
                    used_count--;
                end
            end
            sste_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_used[i] = 1'b0;
                used_count = 0;
            end
            default: ;
        endcase
        r.count = (used_count > COUNT_TOP) ? sste_pkg::COUNT_W'(COUNT_TOP)
                                           : sste_pkg::COUNT_W'(used_count);
        return r;
    endfunction

    function automatic reading_t res(logic h, logic signed [sste_pkg::LEVEL_W-1:0] l,
                                     logic d, logic [sste_pkg::COUNT_W-1:0] c);
        reading_t r;
        r.hit     = h;
        r.level   = l;
        r.dropped = d;
        r.count   = c;
        return r;
    endfunction

    function automatic item_t make_random_item();
        item_t it;
        int    r;
        int    s;
        r = $urandom_range(99);
        if (r < 42)
            it.func = sste_pkg::OP_OBSERVE;
        else if (r < 77)
            it.func = sste_pkg::OP_LOOKUP;
        else if (r < 87)
            it.func = sste_pkg::OP_FORGET;
        else if (r < 89)
            it.func = sste_pkg::OP_CLEAR;
        else if (r < 94)
            it.func = sste_pkg::OP_SIZE;
        else
            it.func = OP_SPARE_LO
                      + sste_pkg::FUNC_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
        if ($urandom_range(99) < 5)
            it.addr = sste_pkg::ADDR_W'({$urandom, $urandom});
        else
            it.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        it.level = sste_pkg::LEVEL_W'($urandom);
        clock_ms = clock_ms + $urandom_range(0, 400);
        it.stamp = clock_ms;
        if (it.func == sste_pkg::OP_LOOKUP)
        begin
            s = find_slot(it.addr);
            if (s >= 0)
            begin
                case ($urandom_range(0, 3))
                    0: it.stamp = slot_time[s] + {1'b0, age_limit} + $urandom_range(0, 2) - 1;
                    1: it.stamp = slot_time[s] + $urandom_range(0, 2000);
                    2: it.stamp = slot_time[s] - $urandom_range(1, 5000);
                    default: it.stamp = $urandom;
                endcase
            end
        end
        else if (it.func != sste_pkg::OP_OBSERVE)
            it.stamp = $urandom;
        else if ($urandom_range(99) < 10)
            it.stamp = clock_ms - $urandom_range(0, 3000);
        return it;
    endfunction

    task automatic add_row(input logic [sste_pkg::FUNC_W-1:0] f,
                           input logic [sste_pkg::ADDR_W-1:0] a,
                           input logic signed [sste_pkg::LEVEL_W-1:0] l,
                           input logic [sste_pkg::STAMP_W-1:0] s,
                           input int reps, input bit typed, input reading_t want);
        row_t row;
        row.it.func  = f;
        row.it.addr  = a;
        row.it.level = l;
        row.it.stamp = s;
        row.reps     = reps;
        row.typed    = typed;
        row.want     = want;
        plan.insert(plan.size(), row);
    endtask

    task automatic note_mismatch(input string msg);
        $display("ERROR at %0t: result %0d: %s", $realtime, results_seen, msg);
        errors++;
    endtask

    task automatic offer_item(input item_t it, input bit typed, input reading_t want);
        reading_t predicted;
        in_valid       <= 1'b1;
        func           <= it.func;
        device_address <= it.addr;
        signal_level   <= it.level;
        stamp_ms       <= it.stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = table_step(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        items_sent++;
        if (!steady && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_age(input logic [sste_pkg::AGE_W-1:0] value);
        cfg_valid  <= 1'b1;
        max_age_ms <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        age_limit = value;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // result checker
    reading_t front_result;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("result with nothing expected");
            else
            begin
                front_result = pending_results.pop_front();
                if (hit !== front_result.hit)
                    note_mismatch($sformatf("hit %b, expected %b", hit, front_result.hit));
                if (stored_level !== front_result.level)
                    note_mismatch($sformatf("stored_level %0d, expected %0d",
                                            stored_level, front_result.level));
                if (dropped !== front_result.dropped)
                    note_mismatch($sformatf("dropped %b, expected %b",
                                            dropped, front_result.dropped));
                if (entry_count !== front_result.count)
                    note_mismatch($sformatf("entry_count %0d, expected %0d",
                                            entry_count, front_result.count));
            end
            results_seen++;
        end
    end

    // receiver
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!receiver_held && results_seen >= HOLD_AT)
            begin
                receiver_held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    // watchdog
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        item_t                      row_item;
        logic [sste_pkg::AGE_W-1:0] phase_age;

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        max_age_ms     <= '0;
        in_valid       <= 1'b0;
        func           <= sste_pkg::OP_SIZE;
        device_address <= '0;
        signal_level   <= '0;
        stamp_ms       <= '0;

        for (int i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;
        used_count    = 0;
        age_limit     = sste_pkg::MAX_AGE_RESET;
        items_sent    = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        lookup_hits   = 0;
        full_drops    = 0;
        errors        = 0;
        steady        = 1'b0;
        receiver_held = 1'b0;
        clock_ms      = $urandom;
        addr_pool[0]  = '0;
        addr_pool[1]  = ADDR_TOP;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = sste_pkg::ADDR_W'({$urandom, $urandom});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_row(sste_pkg::OP_SIZE,    '0, 16'sd0, '0, 1, 1, res(0, 0, 0, 0));
        add_row(sste_pkg::OP_LOOKUP,  '0, 16'sd0, '0, 1, 1, res(0, 0, 0, 0));
        add_row(sste_pkg::OP_FORGET,  ADDR_TOP, 16'sd0, '0, 1, 1, res(0, 0, 0, 0));
        add_row(sste_pkg::OP_OBSERVE, '0, -16'sd32768, '0, 1, 1, res(0, 0, 0, 1));
        add_row(sste_pkg::OP_OBSERVE, ADDR_TOP, 16'sd32767, STAMP_TOP, 1, 1,
                res(0, 0, 0, 2));
        // age exactly at the limit, then one past it
        add_row(sste_pkg::OP_LOOKUP,  '0, 16'sd0, 32'd1000, 1, 1,
                res(1, -16'sd32768, 0, 2));
        add_row(sste_pkg::OP_LOOKUP,  '0, 16'sd0, 32'd1001, 1, 1, res(0, 0, 0, 2));
        // age across the stamp wrap
        add_row(sste_pkg::OP_LOOKUP,  ADDR_TOP, 16'sd0, '0, 1, 1, res(1, 16'sd32767, 0, 2));
        add_row(sste_pkg::OP_LOOKUP,  ADDR_TOP, 16'sd0, 32'h7FFF_FFFE, 1, 1,
                res(0, 0, 0, 2));
        add_row(sste_pkg::OP_OBSERVE, '0, 16'sd5, 32'd5000, 1, 1, res(0, 0, 0, 2));
        // stored time ahead of now
        add_row(sste_pkg::OP_LOOKUP,  '0, 16'sd0, 32'd10, 1, 1, res(1, 16'sd5, 0, 2));
        add_row(sste_pkg::OP_FORGET,  ADDR_TOP, 16'sd0, '0, 1, 1, res(0, 0, 0, 1));
        add_row(sste_pkg::OP_LOOKUP,  ADDR_TOP, 16'sd0, '0, 1, 1, res(0, 0, 0, 1));
        add_row(OP_SPARE_LO, ADDR_TOP, -16'sd1, STAMP_TOP, 1, 1, res(0, 0, 0, 1));
        add_row(OP_SPARE_HI, '0, 16'sd0, '0, 1, 1, res(0, 0, 0, 1));
        // fill the table
        add_row(sste_pkg::OP_OBSERVE, 48'h5555_5555_5555, 16'sh1234, 32'd100, SLOTS - 1, 0,
                '0);
        add_row(sste_pkg::OP_OBSERVE, 48'hAAAA_AAAA_AAAA, -16'sd1, 32'd100, 1, 1,
                res(0, 0, 1, 16));
        add_row(sste_pkg::OP_LOOKUP,  48'hAAAA_AAAA_AAAA, 16'sd0, 32'd100, 1, 1,
                res(0, 0, 0, 16));
        add_row(sste_pkg::OP_OBSERVE, '0, 16'sd7, 32'd200, 1, 1, res(0, 0, 0, 16));
        add_row(sste_pkg::OP_LOOKUP,  '0, 16'sd0, 32'd200, 1, 1, res(1, 16'sd7, 0, 16));
        add_row(sste_pkg::OP_FORGET,  48'h5555_5555_5558, 16'sd0, '0, 1, 1,
                res(0, 0, 0, 15));
        add_row(sste_pkg::OP_OBSERVE, 48'hAAAA_AAAA_AAAA, -16'sd1, 32'd300, 1, 1,
                res(0, 0, 0, 16));
        add_row(sste_pkg::OP_LOOKUP,  48'hAAAA_AAAA_AAAA, 16'sd0, 32'd300, 1, 1,
                res(1, -16'sd1, 0, 16));
        add_row(sste_pkg::OP_CLEAR,   '0, 16'sd0, '0, 1, 1, res(0, 0, 0, 0));
        add_row(sste_pkg::OP_LOOKUP,  '0, 16'sd0, 32'd200, 1, 1, res(0, 0, 0, 0));

        foreach (plan[i])
            for (int k = 0; k < plan[i].reps; k++)
            begin
                row_item      = plan[i].it;
                row_item.addr = plan[i].it.addr + sste_pkg::ADDR_W'(k);
                offer_item(row_item, plan[i].typed, plan[i].want);
            end
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       phase_age = '0;
                1:       phase_age = AGE_TOP;
                2:       phase_age = sste_pkg::AGE_W'($urandom_range(0, 5000));
                default: phase_age = sste_pkg::MAX_AGE_RESET;
            endcase
            steady = (p == 1);
            write_max_age(phase_age);
            repeat (PHASE_ITEMS) offer_item(make_random_item(), 1'b0, '0);
            settle();
        end
        steady = 1'b0;
        repeat (SLOTS + 4) @(posedge clk);

        $display("covered %0d items over %0d age settings; %0d results checked",
                 items_sent, cfg_writes + 1, results_seen);
        $display("lookup hits %0d, observes dropped on a full table %0d, mismatches %0d",
                 lookup_hits, full_drops, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
